/* hw/rtl/sacl_pkg.sv */
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants for the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package sacl_pkg;

    localparam int MAX_INDEX_BITS = 8;
    localparam int WAYS           = 8;
    localparam int SETS           = 1 << MAX_INDEX_BITS;
    localparam int TAG_W          = 64;
    localparam int RANK_W         = 3;
    localparam int WAY_CNT_W      = 4;
    localparam int ROW_W          = WAYS + WAYS * RANK_W;
    localparam int TAG_ROW_W      = WAYS * TAG_W;
    localparam int SET_W          = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 6;
    localparam logic [RANK_W-1:0] RANK_MAX = '1;

    typedef enum logic [1:0] {
        OP_FETCH  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_STORE  = 2'd2,
        OP_MODIFY = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS = 2'd0,
        CFG_WAYS     = 2'd1,
        CFG_OFFSET   = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        S_IDLE,
        S_LOOK
    } t_state;

    typedef struct packed {
        logic [3:0] set_index_bits;
        logic [3:0] ways_in_use;
        logic [5:0] offset_bits;
    } t_cfg;

    typedef struct packed {
        logic             modify;
        logic [SET_W-1:0] set;
        logic [TAG_W-1:0] tag;
    } t_acc;

endpackage

/* hw/rtl/sacl_if.sv */
// ----------------------------------------------------------------------------
// sacl_req_if / sacl_rsp_if
// Valid/ready channels for access requests and per-request results.
// ----------------------------------------------------------------------------
interface sacl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [63:0] address;

    modport source (output valid, output operation, output address, input ready);
    modport sink   (input valid, input operation, input address, output ready);
endinterface

interface sacl_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  hits_now;
    logic        missed;
    logic        evicted;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
    logic [31:0] total_evictions;

    modport source (output valid, output hits_now, output missed, output evicted,
                    output total_hits, output total_misses, output total_evictions,
                    input ready);
    modport sink   (input valid, input hits_now, input missed, input evicted,
                    input total_hits, input total_misses, input total_evictions,
                    output ready);
endinterface

/* hw/rtl/sacl_ram.sv */
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/sacl_front.sv */
// ----------------------------------------------------------------------------
// sacl_front
// Accepts requests, drops fetches, splits the address into set and tag and
// queues the access for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module sacl_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sacl_pkg::t_cfg  i_cfg,
    sacl_req_if.sink        i_req,
    output logic            o_q_vld,
    output sacl_pkg::t_acc  o_q_acc,
    input  logic            i_q_pop
);

    sacl_pkg::t_acc r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;

    logic [3:0]     sb;
    logic [6:0]     sum_sh;
    logic [63:0]    shifted;
    logic [sacl_pkg::SET_W-1:0] mask;
    sacl_pkg::t_acc acc;
    logic           push;

    assign i_req.ready = (r_cnt != 2'd2);

    // split address into set and tag
    always_comb begin
        sb = (i_cfg.set_index_bits > 4'(sacl_pkg::MAX_INDEX_BITS))
             ? 4'(sacl_pkg::MAX_INDEX_BITS) : i_cfg.set_index_bits;
        shifted = i_req.address >> i_cfg.offset_bits;
        mask    = sacl_pkg::SET_W'((9'd1 << sb) - 9'd1);
        sum_sh  = 7'(i_cfg.offset_bits) + 7'(sb);
        acc.modify = (sacl_pkg::t_op'(i_req.operation) == sacl_pkg::OP_MODIFY);
        acc.set    = shifted[sacl_pkg::SET_W-1:0] & mask;
        acc.tag    = (sum_sh < 7'd64) ? (i_req.address >> sum_sh[5:0]) : '0;
        push = i_req.valid && i_req.ready
               && (sacl_pkg::t_op'(i_req.operation) != sacl_pkg::OP_FETCH);
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= acc;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

    assign o_q_vld = (r_cnt != 2'd0);
    assign o_q_acc = r_q[r_rp];

endmodule

/* hw/rtl/sacl_back.sv */
// ----------------------------------------------------------------------------
// sacl_back
// Reads the set row, resolves hit, fill or eviction, writes the row back,
// updates the totals and holds the result in an output register.
// ----------------------------------------------------------------------------
module sacl_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sacl_pkg::t_cfg  i_cfg,
    input  logic            i_q_vld,
    input  sacl_pkg::t_acc  i_q_acc,
    output logic            o_q_pop,
    sacl_rsp_if.source      o_rsp
);

    localparam int W  = sacl_pkg::WAYS;
    localparam int RW = sacl_pkg::RANK_W;
    localparam int TW = sacl_pkg::TAG_W;
    localparam int WIX = (W > 1) ? $clog2(W) : 1;

    sacl_pkg::t_state r_state, n_state;
    sacl_pkg::t_acc   r_acc;
    logic [sacl_pkg::SETS-1:0] r_row_vld;
    logic             r_rv;

    logic [sacl_pkg::ROW_W-1:0]     row_rd, row_wr;
    logic [sacl_pkg::TAG_ROW_W-1:0] tag_rd, tag_wr;
    logic                           ram_we, ram_re;

    logic [31:0] r_tot_hit, r_tot_miss, r_tot_evict;
    logic        r_out_vld;
    logic [1:0]  r_hits_now;
    logic        r_missed, r_evicted;

    logic [sacl_pkg::WAY_CNT_W-1:0] n;
    logic [W-1:0]  inuse, vld, hitv, inv, nvld;
    logic [RW-1:0] rec [W];
    logic [RW-1:0] nrec [W];
    logic [TW-1:0] tags [W];
    logic          hit, any_inv;
    logic [WIX-1:0] hj, fj, pick, tj;
    logic [RW-1:0] r_sel;
    logic [1:0]    hits_inc;
    logic [32:0]   sum_h;
    logic          commit, out_free;

    // row memories: valid and ranks, tags
    sacl_ram #(.WIDTH(sacl_pkg::ROW_W), .DEPTH(sacl_pkg::SETS)) u_row_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(r_acc.set), .i_wdata(row_wr),
        .i_re(ram_re), .i_raddr(i_q_acc.set), .o_rdata(row_rd)
    );

    sacl_ram #(.WIDTH(sacl_pkg::TAG_ROW_W), .DEPTH(sacl_pkg::SETS)) u_tag_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(r_acc.set), .i_wdata(tag_wr),
        .i_re(ram_re), .i_raddr(i_q_acc.set), .o_rdata(tag_rd)
    );

    assign out_free = !r_out_vld || o_rsp.ready;

    // sequencer: issue read, then resolve and write back
    always_comb begin
        n_state = r_state;
        ram_re  = 1'b0;
        o_q_pop = 1'b0;
        commit  = 1'b0;
        unique case (r_state)
            sacl_pkg::S_IDLE: begin
                if (i_q_vld) begin
                    ram_re  = 1'b1;
                    o_q_pop = 1'b1;
                    n_state = sacl_pkg::S_LOOK;
                end
            end
            sacl_pkg::S_LOOK: begin
                if (out_free) begin
                    commit  = 1'b1;
                    n_state = sacl_pkg::S_IDLE;
                end
            end
            default: n_state = sacl_pkg::S_IDLE;
        endcase
    end
    assign ram_we = commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sacl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // latch access and row-valid flag with the read
    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_acc <= i_q_acc;
            r_rv  <= r_row_vld[i_q_acc.set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (commit) begin
            r_row_vld[r_acc.set] <= 1'b1;
        end
    end

    // resolve the access against the row
    always_comb begin
        if (i_cfg.ways_in_use == '0) begin
            n = sacl_pkg::WAY_CNT_W'(1);
        end else if (i_cfg.ways_in_use > sacl_pkg::WAY_CNT_W'(W)) begin
            n = sacl_pkg::WAY_CNT_W'(W);
        end else begin
            n = i_cfg.ways_in_use;
        end
        for (int j = 0; j < W; j++) begin
            inuse[j] = (sacl_pkg::WAY_CNT_W'(j) < n);
            vld[j]   = r_rv && row_rd[j];
            rec[j]   = r_rv ? row_rd[W + j*RW +: RW] : '0;
            tags[j]  = tag_rd[j*TW +: TW];
            hitv[j]  = inuse[j] && vld[j] && (tags[j] == r_acc.tag);
            inv[j]   = inuse[j] && !vld[j];
        end
        hit = |hitv;
        any_inv = |inv;
        hj = '0;
        fj = '0;
        for (int j = W - 1; j >= 0; j--) begin
            if (hitv[j]) hj = WIX'(j);
            if (inv[j])  fj = WIX'(j);
        end
        pick = '0;
        for (int j = 1; j < W; j++) begin
            if (inuse[j] && rec[j] > rec[pick]) pick = WIX'(j);
        end
        nvld = vld;
        for (int j = 0; j < W; j++) begin
            nrec[j] = rec[j];
        end
        tj = pick;
        r_sel = '0;
        if (hit) begin
            tj = hj;
            r_sel = rec[hj];
            for (int k = 0; k < W; k++) begin
                if (inuse[k] && WIX'(k) != hj && vld[k] && rec[k] < r_sel)
                    nrec[k] = rec[k] + 1'b1;
            end
        end else if (any_inv) begin
            tj = fj;
            for (int k = 0; k < W; k++) begin
                if (inuse[k] && vld[k] && rec[k] != sacl_pkg::RANK_MAX)
                    nrec[k] = rec[k] + 1'b1;
            end
            nvld[fj] = 1'b1;
        end else begin
            r_sel = rec[pick];
            for (int k = 0; k < W; k++) begin
                if (inuse[k] && WIX'(k) != pick && rec[k] < r_sel)
                    nrec[k] = rec[k] + 1'b1;
            end
        end
        nrec[tj] = '0;
        row_wr = '0;
        tag_wr = tag_rd;
        for (int j = 0; j < W; j++) begin
            row_wr[j] = nvld[j];
            row_wr[W + j*RW +: RW] = nrec[j];
        end
        tag_wr[tj*TW +: TW] = r_acc.tag;
        // second access of a modify always hits
        hits_inc = 2'(hit) + 2'(r_acc.modify);
        sum_h = {1'b0, r_tot_hit} + 33'(hits_inc);
    end

    // totals and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot_hit   <= '0;
            r_tot_miss  <= '0;
            r_tot_evict <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (commit) begin
                r_tot_hit <= sum_h[32] ? '1 : sum_h[31:0];
                if (!hit && r_tot_miss != '1) r_tot_miss <= r_tot_miss + 32'd1;
                if (!hit && !any_inv && r_tot_evict != '1)
                    r_tot_evict <= r_tot_evict + 32'd1;
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_hits_now <= hits_inc;
            r_missed   <= !hit;
            r_evicted  <= !hit && !any_inv;
        end
    end

    assign o_rsp.valid           = r_out_vld;
    assign o_rsp.hits_now        = r_hits_now;
    assign o_rsp.missed          = r_missed;
    assign o_rsp.evicted         = r_evicted;
    assign o_rsp.total_hits      = r_tot_hit;
    assign o_rsp.total_misses    = r_tot_miss;
    assign o_rsp.total_evictions = r_tot_evict;

endmodule

/* hw/rtl/set_assoc_lru_cache_model.sv */
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// Set-associative cache with LRU replacement, counting hits, misses and
// evictions over a trace of accesses.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  i_req     in   valid/ready   operation, address
//  o_rsp     out  valid/ready   hits_now, missed, evicted, totals
//  i_cfg_*   in   write enable  register index, data
//
//  Each load, store or modify passes through the back end as a set-row
//  read, then resolve and write-back of the row memories (one port each).
//  A modify resolves both accesses in the same write-back. Fetches are
//  dropped in the front end and give no result.
//  Reset clears the per-set valid flags at once; no clearing pass.
//  A two-entry queue decouples front and back; a stalled result holds the
//  back end while the front keeps accepting until the queue is full.
module set_assoc_lru_cache_model (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sacl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sacl_req_if.sink                        i_req,
    sacl_rsp_if.source                      o_rsp
);

    sacl_pkg::t_cfg r_cfg;
    logic           q_vld, q_pop;
    sacl_pkg::t_acc q_acc;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_index_bits <= 4'd0;
            r_cfg.ways_in_use    <= 4'd1;
            r_cfg.offset_bits    <= 6'd0;
        end else if (i_cfg_we) begin
            case (sacl_pkg::t_cfg_idx'(i_cfg_idx))
                sacl_pkg::CFG_SET_BITS: r_cfg.set_index_bits <= i_cfg_data[3:0];
                sacl_pkg::CFG_WAYS:     r_cfg.ways_in_use    <= i_cfg_data[3:0];
                sacl_pkg::CFG_OFFSET:   r_cfg.offset_bits    <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    sacl_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_req(i_req),
        .o_q_vld(q_vld), .o_q_acc(q_acc), .i_q_pop(q_pop)
    );

    sacl_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_q_vld(q_vld), .i_q_acc(q_acc), .o_q_pop(q_pop), .o_rsp(o_rsp)
    );

    // two hits means the first access hit
    a_two_hits_no_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.hits_now == 2'd2 |-> !o_rsp.missed)
        else $error("two hits reported with a miss");

    // an eviction only follows a miss
    a_evict_needs_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.evicted |-> o_rsp.missed)
        else $error("eviction without miss");

    // queue pop only with a queued access
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_vld)
        else $error("pop from empty queue");

endmodule
